// File: hdl/pu2x_pkg.sv
// ----------------------------------------------------------------------------
// pu2x_pkg
// Shared types, constants and helpers of the 2x nearest-neighbour upscaler.
// ----------------------------------------------------------------------------
package pu2x_pkg;

  localparam int           WIDTH_BITS      = 7;
  localparam int           PIXEL_BITS      = 16;
  localparam int           COUNT_BITS      = 3;
  localparam logic [6:0]   WIDTH_RESET     = 7'd120;
  localparam logic [2:0]   PIX_COUNT_FULL  = 3'd4;
  localparam logic [2:0]   PIX_COUNT_HALF  = 3'd2;

  typedef enum logic [1:0] {
    ST_PASS,
    ST_READ,
    ST_SEND
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic load_replay;
    logic idx_clr;
    logic idx_inc;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic row_end;
    logic idx_last;
    logic out_free;
  } dp_status_t;

  function automatic logic [15:0] swap_bytes(input logic [15:0] p);
    return {p[7:0], p[15:8]};
  endfunction

endpackage

// File: hdl/pu2x_ctrl.sv
// ----------------------------------------------------------------------------
// pu2x_ctrl
// Sequencer: passes source pairs through, then steps the row replay.
// ----------------------------------------------------------------------------
module pu2x_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  pu2x_pkg::dp_status_t status,
  output pu2x_pkg::dp_cmd_t    cmd
);

  pu2x_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pu2x_pkg::ST_PASS;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    src_stall  = 1'b1;
    unique case (state)
      pu2x_pkg::ST_PASS: begin
        src_stall   = !status.out_free;
        cmd.load_in = src_valid && status.out_free;
        if (cmd.load_in && status.row_end) begin
          cmd.idx_clr = 1'b1;
          state_next  = pu2x_pkg::ST_READ;
        end
      end
      pu2x_pkg::ST_READ: begin
        // first stored pair is fetched here, ahead of its result
        cmd.rd_en  = 1'b1;
        state_next = pu2x_pkg::ST_SEND;
      end
      pu2x_pkg::ST_SEND: begin
        if (status.out_free) begin
          cmd.load_replay = 1'b1;
          if (status.idx_last) begin
            state_next = pu2x_pkg::ST_PASS;
          end else begin
            cmd.idx_inc = 1'b1;
            cmd.rd_en   = 1'b1;
          end
        end
      end
      default: begin
        state_next = pu2x_pkg::ST_PASS;
      end
    endcase
  end

endmodule

// File: hdl/pu2x_datapath.sv
// ----------------------------------------------------------------------------
// pu2x_datapath
// Width register, pair position, line store and the output register.
// ----------------------------------------------------------------------------
module pu2x_datapath #(
  parameter int MAX_SOURCE_WIDTH = 120
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [6:0]           source_width,
  input  logic [15:0]          pixel_a,
  input  logic [15:0]          pixel_b,
  input  pu2x_pkg::dp_cmd_t    cmd,
  output pu2x_pkg::dp_status_t status,
  output logic                 dst_valid,
  input  logic                 dst_stall,
  output logic [15:0]          out_pixel_0,
  output logic [15:0]          out_pixel_1,
  output logic [15:0]          out_pixel_2,
  output logic [15:0]          out_pixel_3,
  output logic [2:0]           pixel_count,
  output logic                 is_repeat_row,
  output logic                 last
);

  // the width register cannot exceed 127, so neither can the usable width
  localparam int         WCAP        = (MAX_SOURCE_WIDTH < 127) ? MAX_SOURCE_WIDTH : 127;
  localparam int         STORE_DEPTH = (WCAP + 1) / 2;
  localparam int         PW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [6:0] WCAP_W      = 7'(WCAP);

  logic [6:0]    width_setting;
  logic [6:0]    width_act;
  logic [6:0]    width_m1;
  logic [5:0]    last_pair;
  logic [PW-1:0] last_idx;
  logic          odd;

  logic [PW-1:0] pos;
  logic [PW-1:0] idx;
  logic [PW-1:0] rd_addr;
  logic [31:0]   row_store [STORE_DEPTH];
  logic [31:0]   rd_q;

  logic          row_end;
  logic          count_full;
  logic          rep_full;
  logic          idx_last;
  logic [15:0]   sw_a;
  logic [15:0]   sw_b;
  logic [31:0]   in_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_setting <= pu2x_pkg::WIDTH_RESET;
    end else if (cfg_valid) begin
      width_setting <= source_width;
    end
  end

  always_comb begin
    priority if (width_setting == 7'd0) begin
      width_act = 7'd1;
    end else if (width_setting > WCAP_W) begin
      width_act = WCAP_W;
    end else begin
      width_act = width_setting;
    end
  end

  assign width_m1  = width_act - 7'd1;
  assign last_pair = width_m1[6:1];
  assign last_idx  = last_pair[PW-1:0];
  assign odd       = width_act[0];

  assign row_end    = (pos >= last_idx);
  assign count_full = !((pos == last_idx) && odd);
  assign sw_a       = pu2x_pkg::swap_bytes(pixel_a);
  assign sw_b       = pu2x_pkg::swap_bytes(pixel_b);
  assign in_word    = {(count_full ? sw_b : 16'h0000), sw_a};

  assign idx_last = (idx == last_idx);
  assign rep_full = !(idx_last && odd);
  assign rd_addr  = cmd.idx_inc ? idx + PW'(1) : idx;

  assign status.row_end  = row_end;
  assign status.idx_last = idx_last;
  assign status.out_free = !dst_valid || !dst_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (cmd.load_in) begin
      pos <= row_end ? '0 : pos + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + PW'(1);
    end
  end

  // line store: one write port for the incoming pair, one registered read
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      row_store[pos] <= in_word;
    end
    if (cmd.rd_en) begin
      rd_q <= row_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (cmd.load_in || cmd.load_replay) begin
      dst_valid <= 1'b1;
    end else if (!dst_stall) begin
      dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      out_pixel_0   <= sw_a;
      out_pixel_1   <= sw_a;
      out_pixel_2   <= in_word[31:16];
      out_pixel_3   <= in_word[31:16];
      pixel_count   <= count_full ? pu2x_pkg::PIX_COUNT_FULL : pu2x_pkg::PIX_COUNT_HALF;
      is_repeat_row <= 1'b0;
      last          <= !row_end;
    end else if (cmd.load_replay) begin
      out_pixel_0   <= rd_q[15:0];
      out_pixel_1   <= rd_q[15:0];
      out_pixel_2   <= rep_full ? rd_q[31:16] : 16'h0000;
      out_pixel_3   <= rep_full ? rd_q[31:16] : 16'h0000;
      pixel_count   <= rep_full ? pu2x_pkg::PIX_COUNT_FULL : pu2x_pkg::PIX_COUNT_HALF;
      is_repeat_row <= 1'b1;
      last          <= idx_last;
    end
  end

  a_pos_in_store: assert property (@(posedge clk) disable iff (rst)
    pos <= PW'(STORE_DEPTH - 1))
    else $error("pair position beyond line store");

  a_row_end_wraps: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_in && row_end) |=> (pos == '0))
    else $error("pair position not reset at row end");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_in && cmd.load_replay))
    else $error("pass-through and replay loaded together");

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> (pixel_count == pu2x_pkg::PIX_COUNT_FULL ||
                   pixel_count == pu2x_pkg::PIX_COUNT_HALF))
    else $error("illegal pixel count");

endmodule

// File: hdl/pixel_upscale_2x_nearest_core.sv
// ----------------------------------------------------------------------------
// pixel_upscale_2x_nearest_core
// 2x nearest-neighbour upscaler for RGB565 pixels with a one-row line store.
// ----------------------------------------------------------------------------
// Source pairs enter on src_* (valid/stall) in raster order; each pixel is
// byte-swapped and doubled horizontally, giving up to four display pixels per
// result on dst_* (valid/stall). After the last pair of a row the stored row
// is replayed once (is_repeat_row set), its final result marked last.
// source_width is written over cfg_valid/cfg_ready, which is always ready;
// write it only while no transaction is in flight.
// A result appears in the output register in the cycle after its pair is
// accepted. A row's pairs are accepted first, then the first stored pair is
// fetched, then one replay result follows per cycle while the receiver does
// not stall; the replay is paced by the single read port of the line store.
// A finished result waits in the output register while the next pair is
// taken, as long as the receiver drains it; while dst_stall holds a result
// the block stalls its source and the replay halts in place.
// Reset clears the pair position and restores source_width to 120; the line
// store contents are undefined and are never read before being written.
// ----------------------------------------------------------------------------
module pixel_upscale_2x_nearest_core #(
  parameter int MAX_SOURCE_WIDTH = 120
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  source_width,
  input  logic        src_valid,
  output logic        src_stall,
  input  logic [15:0] pixel_a,
  input  logic [15:0] pixel_b,
  output logic        dst_valid,
  input  logic        dst_stall,
  output logic [15:0] out_pixel_0,
  output logic [15:0] out_pixel_1,
  output logic [15:0] out_pixel_2,
  output logic [15:0] out_pixel_3,
  output logic [2:0]  pixel_count,
  output logic        is_repeat_row,
  output logic        last
);

  pu2x_pkg::dp_cmd_t    cmd;
  pu2x_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  pu2x_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pu2x_datapath #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .source_width  (source_width),
    .pixel_a       (pixel_a),
    .pixel_b       (pixel_b),
    .cmd           (cmd),
    .status        (status),
    .dst_valid     (dst_valid),
    .dst_stall     (dst_stall),
    .out_pixel_0   (out_pixel_0),
    .out_pixel_1   (out_pixel_1),
    .out_pixel_2   (out_pixel_2),
    .out_pixel_3   (out_pixel_3),
    .pixel_count   (pixel_count),
    .is_repeat_row (is_repeat_row),
    .last          (last)
  );

endmodule

// File: bench/pu2x_checker.sv
// ----------------------------------------------------------------------------
// pu2x_checker
// Scoreboard for the 2x nearest-neighbour upscaler.
// Follows width writes and source transactions, predicts each display result
// (byte swap, horizontal doubling, replay of the stored row) and compares the
// display transactions in order against the predicted queue.
// ----------------------------------------------------------------------------
module pu2x_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [6:0]  source_width,
  input  logic        src_valid,
  input  logic        src_stall,
  input  logic [15:0] pixel_a,
  input  logic [15:0] pixel_b,
  input  logic        dst_valid,
  input  logic        dst_stall,
  input  logic [15:0] out_pixel_0,
  input  logic [15:0] out_pixel_1,
  input  logic [15:0] out_pixel_2,
  input  logic [15:0] out_pixel_3,
  input  logic [2:0]  pixel_count,
  input  logic        is_repeat_row,
  input  logic        last,
  output int          fail_count,
  output int          outstanding,
  output int          results_seen,
  output int          rows_replayed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH  = 120;
  localparam int LINE_PAIRS = (MAX_WIDTH + 1) / 2;

  typedef struct packed {
    logic [15:0] pix0;
    logic [15:0] pix1;
    logic [15:0] pix2;
    logic [15:0] pix3;
    logic [2:0]  count;
    logic        replay;
    logic        tail;
  } disp_beat_t;

  disp_beat_t  display_q[$];
  logic [31:0] line_copy [LINE_PAIRS];
  logic [5:0]  next_pair;
  logic [6:0]  width_setting;

  function automatic disp_beat_t make_beat(input logic [31:0] word, input logic [2:0] count,
                                           input logic replay, input logic tail);
    disp_beat_t b;
    b.pix0   = word[15:0];
    b.pix1   = word[15:0];
    b.pix2   = (count == pu2x_pkg::PIX_COUNT_FULL) ? word[31:16] : 16'h0000;
    b.pix3   = b.pix2;
    b.count  = count;
    b.replay = replay;
    b.tail   = tail;
    return b;
  endfunction

  function automatic string beat_text(input disp_beat_t b);
    return $sformatf("%h %h %h %h count=%0d repeat=%0b last=%0b",
                     b.pix0, b.pix1, b.pix2, b.pix3, b.count, b.replay, b.tail);
  endfunction

  // Queue the results of one source pair, and the row replay at the row's end
  task automatic upscale_pair(input logic [15:0] a, input logic [15:0] b);
    int          span;
    int          pairs;
    int          end_pair;
    logic        odd;
    logic        row_done;
    logic [2:0]  count;
    logic [2:0]  rep_count;
    logic [31:0] word;
    span = width_setting;
    if (span == 0) span = 1;
    if (span > MAX_WIDTH) span = MAX_WIDTH;
    pairs    = (span + 1) / 2;
    end_pair = pairs - 1;
    odd      = (span % 2) == 1;
    // a width cut mid-row can leave the position past the new last pair
    row_done = (next_pair >= end_pair);
    count    = (next_pair == end_pair && odd) ? pu2x_pkg::PIX_COUNT_HALF
                                              : pu2x_pkg::PIX_COUNT_FULL;
    word     = {16'h0000, a[7:0], a[15:8]};
    if (count == pu2x_pkg::PIX_COUNT_FULL) word[31:16] = {b[7:0], b[15:8]};
    if (next_pair < LINE_PAIRS) line_copy[next_pair] = word;
    display_q.push_back(make_beat(word, count, 1'b0, !row_done));
    if (!row_done) begin
      next_pair = next_pair + 6'd1;
    end else begin
      for (int i = 0; i < pairs; i++) begin
        rep_count = (i == end_pair && odd) ? pu2x_pkg::PIX_COUNT_HALF
                                           : pu2x_pkg::PIX_COUNT_FULL;
        display_q.push_back(make_beat(line_copy[i], rep_count, 1'b1, i == end_pair));
      end
      next_pair = '0;
    end
  endtask

  always @(posedge clk) begin : watch
    disp_beat_t got;
    disp_beat_t want;
    if (rst) begin
      display_q.delete();
      next_pair     = '0;
      width_setting = pu2x_pkg::WIDTH_RESET;
      fail_count    = 0;
      results_seen  = 0;
      rows_replayed = 0;
    end else begin
      // compare before queueing: no result can leave in the cycle its pair enters
      if (dst_valid && !dst_stall) begin
        got = {out_pixel_0, out_pixel_1, out_pixel_2, out_pixel_3,
               pixel_count, is_repeat_row, last};
        results_seen++;
        if (got.replay && got.tail) rows_replayed++;
        if (display_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected display transaction: expected none, actual %s",
                   $time, beat_text(got));
        end else begin
          want = display_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: display mismatch: expected %s, actual %s",
                     $time, beat_text(want), beat_text(got));
          end
        end
      end
      if (cfg_valid && cfg_ready) width_setting = source_width;
      if (src_valid && !src_stall) upscale_pair(pixel_a, pixel_b);
    end
    outstanding <= display_q.size();
  end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the 2x nearest-neighbour upscaler.
// Runs directed rows at the width extremes and across mid-row width changes,
// then random rows over many widths with random source gaps and display
// stalls; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PAIRS = 460;
  localparam int CALM_PAIRS   = 70;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int TAIL_CYCLES  = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  source_width = 7'd0;
  logic        src_valid = 1'b0;
  logic        src_stall;
  logic [15:0] pixel_a = 16'h0000;
  logic [15:0] pixel_b = 16'h0000;
  logic        dst_valid;
  logic        dst_stall = 1'b0;
  logic [15:0] out_pixel_0;
  logic [15:0] out_pixel_1;
  logic [15:0] out_pixel_2;
  logic [15:0] out_pixel_3;
  logic [2:0]  pixel_count;
  logic        is_repeat_row;
  logic        last;

  int fail_count;
  int outstanding;
  int results_seen;
  int rows_replayed;

  int cycle_count;
  int pairs_sent   = 0;
  int width_writes = 0;
  int stall_left   = 0;
  int quiet_left   = 0;
  bit calm         = 1'b0;
  bit src_gaps     = 1'b1;

  pixel_upscale_2x_nearest_core #(.MAX_SOURCE_WIDTH(120)) dut (.*);

  pu2x_checker watch (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Display stalls in bursts, with quiet stretches between
  always @(posedge clk) begin
    if (rst || calm) begin
      dst_stall <= 1'b0;
      stall_left = 0;
      quiet_left = 0;
    end else if (stall_left > 0) begin
      dst_stall <= 1'b1;
      stall_left--;
    end else if (quiet_left > 0) begin
      dst_stall <= 1'b0;
      quiet_left--;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: begin
          dst_stall <= 1'b1;
          stall_left = $urandom_range(0, 10);
        end
        2: begin
          dst_stall <= 1'b0;
          quiet_left = $urandom_range(20, 80);
        end
        default: dst_stall <= 1'b0;
      endcase
    end
  end

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pair(input logic [15:0] a, input logic [15:0] b);
    int gap;
    gap = 0;
    if (!calm && src_gaps && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    pixel_a   <= a;
    pixel_b   <= b;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    pairs_sent++;
  endtask

  // Hold the source until every predicted result has been taken
  task automatic drain();
    src_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_width(input logic [6:0] w);
    drain();
    cfg_valid    <= 1'b1;
    source_width <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    width_writes++;
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run stopped after %0d cycles with %0d results still due",
             $time, cycle_count, outstanding);
    $display("pixel_upscale_2x_nearest_core regression: fail");
    $finish;
  end

  initial begin
    int         target;
    int         phase;
    int         pick;
    int         span;
    int         pairs;
    int         budget;
    logic [6:0] w;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset width: three pairs into a 120-wide row, then shrink to one pixel so
    // the next pair lies past the last pair and closes the row
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'h00FF, 16'hFF00);
    write_width(7'd1);
    send_pair(16'h1234, 16'hABCD);
    send_pair(16'hFFFF, 16'h5A5A);
    send_pair(16'h0001, 16'h8000);
    // zero width behaves as one pixel
    write_width(7'd0);
    send_pair(16'hFF00, 16'h0000);
    send_pair(16'h00FF, 16'hFFFF);
    write_width(7'd2);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h8001, 16'h0180);
    // odd width: half tail pair
    write_width(7'd3);
    send_pair(16'h0F0F, 16'hF0F0);
    send_pair(16'hA5A5, 16'h5A5A);
    // narrow mid-row: the next pair ends the row with a full count
    write_width(7'd8);
    send_pair(16'h1111, 16'h2222);
    send_pair(16'h3333, 16'h4444);
    send_pair(16'h5555, 16'h6666);
    write_width(7'd4);
    send_pair(16'h7777, 16'h8888);
    send_pair(16'h9999, 16'hAAAA);
    send_pair(16'hBBBB, 16'hCCCC);
    // widen mid-row: the row runs on to the new end
    send_pair(16'hDDDD, 16'hEEEE);
    write_width(7'd10);
    repeat (4) send_pair(pick_pixel(), pick_pixel());

    target = pairs_sent + RANDOM_PAIRS;
    phase  = 0;
    while (pairs_sent < target) begin
      if (phase == 0) begin
        w = 7'd127;
      end else if (phase == 1) begin
        w = 7'd119;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) w = 7'($urandom_range(120, 127));
        else if (pick == 1) w = 7'd0;
        else if (pick < 4) w = 7'($urandom_range(25, 119));
        else w = 7'($urandom_range(1, 24));
      end
      write_width(w);
      span   = (w == 0) ? 1 : ((w > 120) ? 120 : w);
      pairs  = (span + 1) / 2;
      budget = (pairs > 20) ? pairs : pairs * $urandom_range(1, 4);
      // cut some phases short so the next width lands mid-row
      if ($urandom_range(0, 4) == 0) budget = $urandom_range(1, budget);
      src_gaps = ($urandom_range(0, 3) != 0);
      repeat (budget) begin
        if (pairs_sent >= target) break;
        calm = (pairs_sent >= target - CALM_PAIRS);
        send_pair(pick_pixel(), pick_pixel());
      end
      phase++;
    end

    calm = 1'b1;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d source pairs and checked %0d display results over %0d width writes,",
             pairs_sent, results_seen, width_writes);
    $display("with zero, odd, saturated and mid-row width changes and %0d row replays.",
             rows_replayed);
    if (fail_count == 0) begin
      $display("pixel_upscale_2x_nearest_core regression: pass");
    end else begin
      $display("pixel_upscale_2x_nearest_core regression: fail");
    end
    $finish;
  end

endmodule
